[rtl/csl_pkg.sv]
package csl_pkg;

    localparam int ACT_W   = 3;
    localparam int POS_W   = 5;
    localparam int FIELD_W = 64;
    localparam int COUNT_W = 5;

    localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_OVERWRITE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SIZE      = 3'd5;

    typedef struct packed {
        logic capture;
        logic append;
        logic overwrite;
        logic clear;
        logic rd_issue;
        logic res_set;
        logic res_ok;
        logic res_rd;
        logic scan_start;
        logic scan_step;
        logic scan_commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             full;
        logic             empty;
        logic             pos_ok;
        logic             scan_end;
        logic             out_free;
    } sts_t;

endpackage

[rtl/csl_ctrl.sv]
module csl_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  csl_pkg::sts_t sts,
    output csl_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next  = ST_DONE;
                cmd.res_set = 1'b1;
                case (sts.action)
                    csl_pkg::ACT_APPEND:
                    begin
                        cmd.append = !sts.full;
                        cmd.res_ok = !sts.full;
                    end
                    csl_pkg::ACT_REMOVE:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.res_set    = 1'b0;
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    csl_pkg::ACT_READ:
                    begin
                        if (sts.pos_ok)
                        begin
                            cmd.res_set  = 1'b0;
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_RDWAIT;
                        end
                    end
                    csl_pkg::ACT_OVERWRITE:
                    begin
                        cmd.overwrite = sts.pos_ok;
                        cmd.res_ok    = sts.pos_ok;
                    end
                    csl_pkg::ACT_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.res_ok = 1'b1;
                    end
                    csl_pkg::ACT_SIZE:
                    begin
                        cmd.res_ok = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_ok = 1'b0;
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                cmd.res_set = 1'b1;
                cmd.res_ok  = 1'b1;
                cmd.res_rd  = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_end)
                begin
                    cmd.scan_commit = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/csl_dpath.sv]
module csl_dpath
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  csl_pkg::cmd_t                  cmd,
    output csl_pkg::sts_t                  sts,
    input  logic [csl_pkg::ACT_W-1:0]      action,
    input  logic [csl_pkg::POS_W-1:0]      position,
    input  logic [csl_pkg::FIELD_W-1:0]    value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output logic [csl_pkg::FIELD_W-1:0]    read_word,
    output logic [csl_pkg::COUNT_W-1:0]    count,
    output logic                           is_empty,
    output logic                           is_full
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = (CW > csl_pkg::POS_W) ? CW : csl_pkg::POS_W;

    logic [WORD_BITS-1:0]         mem_reg [DEPTH];
    logic [WORD_BITS-1:0]         rdata_reg;

    logic [csl_pkg::ACT_W-1:0]    act_reg;
    logic [csl_pkg::POS_W-1:0]    pos_reg;
    logic [WORD_BITS-1:0]         val_reg;

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                ptr_reg;
    logic [CW-1:0]                ptr_next;
    logic                         chk_vld_reg;
    logic                         chk_vld_next;
    logic [AW-1:0]                chk_idx_reg;
    logic [AW-1:0]                chk_idx_next;
    logic                         found_reg;
    logic                         found_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic                         res_ok_reg;
    logic [WORD_BITS-1:0]         res_word_reg;
    logic                         ok_reg;
    logic [WORD_BITS-1:0]         word_reg;
    logic [CW-1:0]                cnt_reg;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [WORD_BITS-1:0]         mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic                         hit;
    logic                         found_now;
    logic [AW-1:0]                pos_addr;
    logic [MW-1:0]                pos_wide;
    logic [MW-1:0]                count_wide;

    assign pos_wide   = MW'(pos_reg);
    assign count_wide = MW'(count_reg);
    assign pos_addr   = AW'(pos_reg - csl_pkg::POS_W'(1));
    assign hit        = (rdata_reg == val_reg);
    assign found_now  = found_reg | (chk_vld_reg & hit);

    assign sts.action   = act_reg;
    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.pos_ok   = (pos_wide != '0) && (pos_wide <= count_wide);
    assign sts.scan_end = chk_vld_reg && ((CW'(chk_idx_reg) + CW'(1)) == count_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        mem_we       = 1'b0;
        mem_waddr    = AW'(count_reg);
        mem_wdata    = val_reg;
        mem_re       = 1'b0;
        mem_raddr    = pos_addr;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        found_next   = found_reg;

        if (cmd.append)
        begin
            mem_we     = 1'b1;
            count_next = count_reg + CW'(1);
        end
        if (cmd.overwrite)
        begin
            mem_we    = 1'b1;
            mem_waddr = pos_addr;
        end
        if (cmd.clear)
        begin
            count_next = '0;
        end
        if (cmd.rd_issue)
        begin
            mem_re = 1'b1;
        end
        if (cmd.scan_start)
        begin
            ptr_next     = '0;
            chk_vld_next = 1'b0;
            found_next   = 1'b0;
        end
        if (cmd.scan_step)
        begin
            if (ptr_reg < count_reg)
            begin
                mem_re       = 1'b1;
                mem_raddr    = AW'(ptr_reg);
                ptr_next     = ptr_reg + CW'(1);
                chk_vld_next = 1'b1;
                chk_idx_next = AW'(ptr_reg);
            end
            else
            begin
                chk_vld_next = 1'b0;
            end
            if (chk_vld_reg)
            begin
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_idx_reg - AW'(1);
                    mem_wdata = rdata_reg;
                end
                else if (hit)
                begin
                    found_next = 1'b1;
                end
            end
        end
        if (cmd.scan_commit && found_now)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem_reg[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            chk_vld_reg   <= chk_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        if (cmd.capture)
        begin
            act_reg <= action;
            pos_reg <= position;
            val_reg <= value[WORD_BITS-1:0];
        end
        if (cmd.res_set)
        begin
            res_ok_reg   <= cmd.res_ok;
            res_word_reg <= cmd.res_rd ? rdata_reg : '0;
        end
        if (cmd.scan_commit)
        begin
            res_ok_reg   <= found_now;
            res_word_reg <= '0;
        end
        if (cmd.load_out)
        begin
            ok_reg   <= res_ok_reg;
            word_reg <= res_word_reg;
            cnt_reg  <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign read_word = csl_pkg::FIELD_W'(word_reg);
    assign count     = csl_pkg::COUNT_W'(cnt_reg);
    assign is_empty  = (cnt_reg == '0);
    assign is_full   = (cnt_reg == CW'(DEPTH));

endmodule

[rtl/compacting_sequential_list_top.sv]
// A request is captured in IDLE and evaluated in EXEC. A read then waits in RDWAIT for
// the entry, and a removal from a non-empty list runs a scan in SCAN. The result then
// waits in DONE until the output register is free. The removal's single pass reads one
// entry a cycle and shifts later entries down behind the match.
// A new request is accepted only once the previous result has been loaded for output.
// Reset is asynchronous and active low; it empties the list, the entries stay undefined.
module compacting_sequential_list_top
#(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [csl_pkg::ACT_W-1:0]      action,
    input  logic [csl_pkg::POS_W-1:0]      position,
    input  logic [csl_pkg::FIELD_W-1:0]    value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ok,
    output logic [csl_pkg::FIELD_W-1:0]    read_word,
    output logic [csl_pkg::COUNT_W-1:0]    count,
    output logic                           is_empty,
    output logic                           is_full
);

    csl_pkg::cmd_t cmd;
    csl_pkg::sts_t sts;

    csl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    csl_dpath
    #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .action    (action),
        .position  (position),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .read_word (read_word),
        .count     (count),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a previous one was still in progress");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result load did not raise out_valid");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.full && sts.empty))
        else $error("list reported both full and empty");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.append, cmd.overwrite, cmd.scan_step}))
        else $error("more than one source drives the entry memory write port");

endmodule
